[src/mesh_relay_suppressor_macros.svh]
// Assertion helpers for the relay suppressor.
`ifndef MESH_RELAY_SUPPRESSOR_MACROS_SVH
`define MESH_RELAY_SUPPRESSOR_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define MRS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define MRS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[src/mrs_pkg.sv]
package mrs_pkg;

  localparam int SLOTS     = 8;
  localparam int SLOT_W    = 3;
  localparam int FRAME_MAX = 64;
  localparam int BYTE_W    = 6;
  localparam int LEN_W     = 7;
  localparam int FADDR_W   = SLOT_W + BYTE_W;

  localparam logic [2:0] FN_FIRST = 3'd0;
  localparam logic [2:0] FN_WRITE = 3'd1;
  localparam logic [2:0] FN_DUP   = 3'd2;
  localparam logic [2:0] FN_TICK  = 3'd3;
  localparam logic [2:0] FN_READ  = 3'd4;

  localparam logic [1:0] REG_JMIN   = 2'd0;
  localparam logic [1:0] REG_JMAX   = 2'd1;
  localparam logic [1:0] REG_THRESH = 2'd2;

  localparam logic [31:0] HASH_GOLD = 32'h9E37_79B1;
  localparam logic [31:0] HASH_MUL  = 32'd31;
  localparam logic [31:0] HASH_MIX  = 32'h2C1B_3C6D;
  localparam int          HASH_SH1  = 15;
  localparam int          HASH_SH2  = 12;
  localparam logic [7:0]  DUP_SAT   = 8'hFF;

  typedef struct packed {
    logic [2:0]  func;
    logic [47:0] sender_mac;
    logic [15:0] seq_num;
    logic [15:0] frame_len;
    logic [31:0] now_ms;
    logic [2:0]  slot_index;
    logic [5:0]  byte_index;
    logic [7:0]  byte_value;
  } req_t;

  typedef struct packed {
    logic        relay_now;
    logic [2:0]  slot_out;
    logic [47:0] out_mac;
    logic [15:0] out_seq;
    logic [6:0]  out_len;
    logic [7:0]  read_byte;
    logic        last;
  } rsp_t;

  typedef struct packed {
    logic [47:0]      mac;
    logic [15:0]      seq;
    logic [7:0]       dup;
    logic [31:0]      fire;
    logic [LEN_W-1:0] len;
  } slot_entry_t;

  typedef struct packed {
    logic              re;
    logic              we;
    logic [SLOT_W-1:0] addr;
    slot_entry_t       wdata;
  } slot_req_t;

  typedef struct packed {
    logic               re;
    logic               we;
    logic [FADDR_W-1:0] addr;
    logic [7:0]         wdata;
  } frame_req_t;

endpackage

[src/mrs_slot_ram.sv]
module mrs_slot_ram
  import mrs_pkg::*;
(
  input  logic        clk,
  input  slot_req_t   req,
  output slot_entry_t rdata
);

  slot_entry_t mem [SLOTS];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.addr];
    end
  end

endmodule

[src/mrs_frame_ram.sv]
module mrs_frame_ram
  import mrs_pkg::*;
(
  input  logic       clk,
  input  frame_req_t req,
  output logic [7:0] rdata
);

  logic [7:0] mem [SLOTS * FRAME_MAX];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.addr];
    end
  end

endmodule

[src/mrs_jitter.sv]
module mrs_jitter
  import mrs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [47:0] mac,
  input  logic [15:0] seq,
  input  logic [15:0] jmin,
  input  logic [15:0] jmax,
  output logic        done,
  output logic [16:0] delay
);

  localparam logic [2:0] P_IDLE = 3'd0;
  localparam logic [2:0] P_SEED = 3'd1;
  localparam logic [2:0] P_BYTE = 3'd2;
  localparam logic [2:0] P_MIX1 = 3'd3;
  localparam logic [2:0] P_MUL2 = 3'd4;
  localparam logic [2:0] P_MIX3 = 3'd5;
  localparam logic [2:0] P_DIV  = 3'd6;
  localparam logic [2:0] P_DONE = 3'd7;

  logic [2:0]  phase;
  logic [2:0]  k;
  logic [4:0]  n;
  logic [31:0] h;
  logic [47:0] mac_sh;
  logic [15:0] seq_r;
  logic [15:0] jmin_r;
  logic [16:0] span;
  logic [16:0] rem;
  logic [16:0] trial;

  assign trial = {rem[15:0], h[31]};
  assign done  = (phase == P_DONE);
  assign delay = {1'b0, jmin_r} + rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= P_IDLE;
    end else begin
      case (phase)
        P_IDLE: begin
          if (start) begin
            mac_sh <= mac;
            seq_r  <= seq;
            jmin_r <= jmin;
            span   <= (jmax >= jmin) ? ({1'b0, jmax} - {1'b0, jmin} + 17'd1) : 17'd1;
            phase  <= P_SEED;
          end
        end
        P_SEED: begin
          h     <= 32'({16'd0, seq_r} * HASH_GOLD);
          k     <= '0;
          phase <= P_BYTE;
        end
        P_BYTE: begin
          h      <= 32'(h * HASH_MUL) + {24'd0, mac_sh[47:40]};
          mac_sh <= {mac_sh[39:0], 8'd0};
          k      <= k + 3'd1;
          if (k == 3'd5) begin
            phase <= P_MIX1;
          end
        end
        P_MIX1: begin
          h     <= h ^ (h >> HASH_SH1);
          phase <= P_MUL2;
        end
        P_MUL2: begin
          h     <= 32'(h * HASH_MIX);
          phase <= P_MIX3;
        end
        P_MIX3: begin
          h     <= h ^ (h >> HASH_SH2);
          rem   <= '0;
          n     <= '0;
          phase <= P_DIV;
        end
        P_DIV: begin
          // restoring remainder, one quotient bit per cycle
          rem <= (trial >= span) ? (trial - span) : trial;
          h   <= {h[30:0], 1'b0};
          n   <= n + 5'd1;
          if (n == 5'd31) begin
            phase <= P_DONE;
          end
        end
        P_DONE: begin
          phase <= P_IDLE;
        end
        default: begin
          phase <= P_IDLE;
        end
      endcase
    end
  end

endmodule

[src/mesh_relay_suppressor.sv]
// First seen: hash and a 32-step modulo in the jitter unit. Duplicate and tick walk the slot RAM;
// a tick also waits on the output. One item is in work at a time.
// Reset (synchronous, rst high): all slots free, config regs to 10/100/3,
// no result pending. Slot and frame memories are not cleared.
`include "mesh_relay_suppressor_macros.svh"

module mesh_relay_suppressor
  import mrs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  req_t        req,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output rsp_t        rsp,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  // sequencer states
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DISP = 4'd1;  // decode the held item
  localparam logic [3:0] S_HASH = 4'd2;  // wait for jitter delay
  localparam logic [3:0] S_DRD  = 4'd3;  // duplicate walk: read slot
  localparam logic [3:0] S_DCHK = 4'd4;  // duplicate walk: compare, bump count
  localparam logic [3:0] S_TRD  = 4'd5;  // tick walk: read slot
  localparam logic [3:0] S_TCHK = 4'd6;  // tick walk: due check, free, report
  localparam logic [3:0] S_RRD  = 4'd7;  // frame byte read data
  localparam logic [3:0] S_TEND = 4'd8;  // flush held result with last set

  logic [3:0]        state;
  req_t              item;
  logic [SLOTS-1:0]  used;
  logic [SLOT_W-1:0] cur;
  logic [15:0]       jmin;
  logic [15:0]       jmax;
  logic [7:0]        thresh;

  // one result is held back so the final one of a tick run can carry last
  logic pend_valid;
  rsp_t pend;

  slot_req_t   slot_req;
  slot_entry_t slot_rd;
  frame_req_t  frame_req;
  logic [7:0]  frame_rd;

  logic        jit_start;
  logic        jit_done;
  logic [16:0] jit_delay;

  logic              any_free;
  logic [SLOT_W-1:0] free_slot;
  logic              fs_ok;
  logic              dup_hit;
  logic              due;
  logic              rep;
  logic              out_free;
  logic              load_out;
  rsp_t              load_data;
  rsp_t              new_rep;
  rsp_t              full_rsp;
  rsp_t              claim_rsp;
  rsp_t              read_rsp;

  mrs_slot_ram u_slot_ram (
    .clk   (clk),
    .req   (slot_req),
    .rdata (slot_rd)
  );

  mrs_frame_ram u_frame_ram (
    .clk   (clk),
    .req   (frame_req),
    .rdata (frame_rd)
  );

  mrs_jitter u_jitter (
    .clk   (clk),
    .rst   (rst),
    .start (jit_start),
    .mac   (item.sender_mac),
    .seq   (item.seq_num),
    .jmin  (jmin),
    .jmax  (jmax),
    .done  (jit_done),
    .delay (jit_delay)
  );

  // new items only in idle; a held result waiting on the output keeps the block out of idle and stalls the input
  assign req_stall = (state != S_IDLE);
  assign out_free  = !rsp_valid || !rsp_stall;

  // lowest free slot
  always_comb begin
    free_slot = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!used[i]) begin
        free_slot = SLOT_W'(i);
      end
    end
  end
  assign any_free = ~&used;
  assign fs_ok    = any_free && (item.frame_len <= 16'(FRAME_MAX));

  assign dup_hit = used[cur] && (slot_rd.seq == item.seq_num) && (slot_rd.mac == item.sender_mac);
  assign due     = used[cur] && (item.now_ms >= slot_rd.fire);
  assign rep     = due && (slot_rd.dup < thresh) && (slot_rd.len != '0);

  always_comb begin
    new_rep          = '0;
    new_rep.slot_out = cur;
    new_rep.out_mac  = slot_rd.mac;
    new_rep.out_seq  = slot_rd.seq;
    new_rep.out_len  = slot_rd.len;
  end

  // single-result transfers: immediate relay, claimed slot, frame byte
  always_comb begin
    full_rsp           = '0;
    full_rsp.relay_now = 1'b1;
    claim_rsp          = '0;
    claim_rsp.slot_out = cur;
    read_rsp           = '0;
    read_rsp.read_byte = frame_rd;
  end

  assign jit_start = (state == S_DISP) && (item.func == FN_FIRST) && fs_ok;

  // memory requests
  always_comb begin
    slot_req  = '0;
    frame_req = '0;
    slot_req.addr  = cur;
    frame_req.addr = {item.slot_index, item.byte_index};
    frame_req.wdata = item.byte_value;
    case (state)
      S_DISP: begin
        frame_req.we = (item.func == FN_WRITE);
        frame_req.re = (item.func == FN_READ);
      end
      S_HASH: begin
        slot_req.we         = jit_done;
        slot_req.wdata.mac  = item.sender_mac;
        slot_req.wdata.seq  = item.seq_num;
        slot_req.wdata.dup  = '0;
        slot_req.wdata.fire = item.now_ms + 32'(jit_delay);
        slot_req.wdata.len  = item.frame_len[LEN_W-1:0];
      end
      S_DRD, S_TRD: begin
        slot_req.re = 1'b1;
      end
      S_DCHK: begin
        // read-modify-write of the count; saturated counts are left alone
        slot_req.we        = dup_hit && (slot_rd.dup != DUP_SAT);
        slot_req.wdata     = slot_rd;
        slot_req.wdata.dup = slot_rd.dup + 8'd1;
      end
      default: begin
      end
    endcase
  end

  // output register load
  always_comb begin
    load_out  = 1'b0;
    load_data = pend;
    case (state)
      S_TCHK: begin
        load_out       = rep && pend_valid && out_free;
        load_data.last = 1'b0;
      end
      S_TEND: begin
        load_out       = pend_valid && out_free;
        load_data.last = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load_out) begin
      rsp_valid <= 1'b1;
    end else if (rsp_valid && !rsp_stall) begin
      rsp_valid <= 1'b0;
    end
    if (load_out) begin
      rsp <= load_data;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      jmin   <= 16'd10;
      jmax   <= 16'd100;
      thresh <= 8'd3;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_JMIN:   jmin   <= cfg_data;
        REG_JMAX:   jmax   <= cfg_data;
        REG_THRESH: thresh <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      used       <= '0;
      pend_valid <= 1'b0;
      cur        <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            item  <= req;
            state <= S_DISP;
          end
        end
        S_DISP: begin
          case (item.func)
            FN_FIRST: begin
              if (fs_ok) begin
                cur   <= free_slot;
                state <= S_HASH;
              end else begin
                pend       <= full_rsp;
                pend_valid <= 1'b1;
                state      <= S_TEND;
              end
            end
            FN_DUP: begin
              cur   <= '0;
              state <= S_DRD;
            end
            FN_TICK: begin
              cur   <= '0;
              state <= S_TRD;
            end
            FN_READ: state <= S_RRD;
            default: state <= S_IDLE;  // byte write done this cycle; unknown codes dropped
          endcase
        end
        S_HASH: begin
          if (jit_done) begin
            used[cur]  <= 1'b1;
            pend       <= claim_rsp;
            pend_valid <= 1'b1;
            state      <= S_TEND;
          end
        end
        S_DRD: begin
          state <= S_DCHK;
        end
        S_DCHK: begin
          if (dup_hit || cur == SLOT_W'(SLOTS - 1)) begin
            state <= S_IDLE;
          end else begin
            cur   <= cur + 1'b1;
            state <= S_DRD;
          end
        end
        S_TRD: begin
          state <= S_TCHK;
        end
        S_TCHK: begin
          // hold here while a second report waits on a full output register
          if (!(rep && pend_valid && !out_free)) begin
            if (due) begin
              used[cur] <= 1'b0;
            end
            if (rep) begin
              pend       <= new_rep;
              pend_valid <= 1'b1;
            end
            if (cur == SLOT_W'(SLOTS - 1)) begin
              state <= S_TEND;
            end else begin
              cur   <= cur + 1'b1;
              state <= S_TRD;
            end
          end
        end
        S_RRD: begin
          pend       <= read_rsp;
          pend_valid <= 1'b1;
          state      <= S_TEND;
        end
        S_TEND: begin
          if (!pend_valid) begin
            state <= S_IDLE;
          end else if (out_free) begin
            pend_valid <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // checks
  `MRS_ASSERT_NOW(a_idle_no_pend, state == S_IDLE, !pend_valid, "held result left in idle")
  `MRS_ASSERT_NEXT(a_claim_sets_used, state == S_HASH && jit_done, used[$past(cur)], "claimed slot not marked used")
  `MRS_ASSERT_NOW(a_dup_used_only, state == S_DCHK && slot_req.we, used[cur], "count bumped on a free slot")
  `MRS_ASSERT_NEXT(a_final_last, state == S_TEND && pend_valid && out_free, rsp_valid && rsp.last, "final result lacks last")

endmodule

[tb/testbench.sv]
module testbench;
  import mrs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Clock, reset and DUT pins. Every input has a known value from time zero.
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_stall;
  req_t        req = '0;
  logic        rsp_valid;
  logic        rsp_stall = 1'b0;
  rsp_t        rsp;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_JMIN;
  logic [15:0] cfg_data = '0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  mesh_relay_suppressor dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Shadow copy of the relay table and its settings.
  logic [15:0] sh_jmin, sh_jmax;
  logic [7:0]  sh_thresh;
  logic        sh_used  [SLOTS];
  logic [47:0] sh_mac   [SLOTS];
  logic [15:0] sh_seq   [SLOTS];
  logic [7:0]  sh_dup   [SLOTS];
  logic [31:0] sh_fire  [SLOTS];
  logic [6:0]  sh_len   [SLOTS];
  logic [7:0]  sh_frame [SLOTS*FRAME_MAX];
  // Bytes written since the slot was last claimed; only these may be read back.
  bit          sh_valid_byte [SLOTS*FRAME_MAX];

  rsp_t        relay_reports_q[$];   // results still owed by the DUT
  int          mismatches = 0;
  bit          calm = 1'b0;         // no sender gaps, no new random receiver stalls while set
  int          hold_req = 0;        // long receiver hold-off request, in cycles
  logic [31:0] clock_ms;            // running time base for stimulus

  // Hash of sender and sequence, folded into the configured jitter window.
  function automatic logic [31:0] relay_delay(logic [47:0] mac, logic [15:0] seq);
    logic [31:0] h, span;
    h = {16'd0, seq} * HASH_GOLD;
    for (int i = 0; i < 6; i++) h = h * HASH_MUL + {24'd0, mac[40-8*i +: 8]};
    h ^= h >> HASH_SH1;
    h *= HASH_MIX;
    h ^= h >> HASH_SH2;
    span = (sh_jmax >= sh_jmin) ? ({16'd0, sh_jmax} - {16'd0, sh_jmin} + 32'd1) : 32'd1;
    return {16'd0, sh_jmin} + (h % span);
  endfunction

  // Advance the shadow table by one accepted request and queue its results.
  task automatic predict_relay(input req_t r);
    rsp_t o;
    rsp_t reps[$];
    int   claim;
    int   fa;
    claim = -1;
    o = '0;
    fa = r.slot_index * FRAME_MAX + r.byte_index;
    case (r.func)
      FN_FIRST: begin
        o.last = 1'b1;
        if (r.frame_len <= FRAME_MAX)
          for (int s = 0; s < SLOTS; s++)
            if (!sh_used[s] && claim < 0) claim = s;
        if (claim < 0) begin
          o.relay_now = 1'b1;
        end else begin
          sh_used[claim] = 1'b1;
          sh_mac[claim]  = r.sender_mac;
          sh_seq[claim]  = r.seq_num;
          sh_dup[claim]  = '0;
          sh_fire[claim] = r.now_ms + relay_delay(r.sender_mac, r.seq_num);
          sh_len[claim]  = r.frame_len[6:0];
          for (int b = 0; b < FRAME_MAX; b++) sh_valid_byte[claim*FRAME_MAX+b] = 1'b0;
          o.slot_out = claim[2:0];
        end
        relay_reports_q.push_back(o);
      end
      FN_WRITE: begin
        sh_frame[fa] = r.byte_value;
        sh_valid_byte[fa] = 1'b1;
      end
      FN_DUP: begin
        for (int s = 0; s < SLOTS; s++)
          if (claim < 0 && sh_used[s] && sh_seq[s] == r.seq_num && sh_mac[s] == r.sender_mac) begin
            claim = s;
            if (sh_dup[s] != DUP_SAT) sh_dup[s]++;
          end
      end
      FN_TICK: begin
        for (int s = 0; s < SLOTS; s++)
          if (sh_used[s] && r.now_ms >= sh_fire[s]) begin
            if (sh_dup[s] < sh_thresh && sh_len[s] != 0) begin
              o = '0;
              o.slot_out = s[2:0];
              o.out_mac  = sh_mac[s];
              o.out_seq  = sh_seq[s];
              o.out_len  = sh_len[s];
              reps.push_back(o);
            end
            sh_used[s] = 1'b0;
          end
        if (reps.size() > 0) reps[reps.size()-1].last = 1'b1;
        foreach (reps[i]) relay_reports_q.push_back(reps[i]);
      end
      FN_READ: begin
        o.read_byte = sh_frame[fa];
        o.last = 1'b1;
        relay_reports_q.push_back(o);
      end
      default: ;  // unused func codes are dropped by the block
    endcase
  endtask

  // Result checker: every result transfer is matched against the oldest expectation.
  always @(posedge clk) begin
    rsp_t e;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (relay_reports_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", rsp);
      end else begin
        e = relay_reports_q.pop_front();
        if (rsp.relay_now !== e.relay_now || rsp.slot_out !== e.slot_out ||
            rsp.out_mac !== e.out_mac || rsp.out_seq !== e.out_seq ||
            rsp.out_len !== e.out_len || rsp.read_byte !== e.read_byte ||
            rsp.last !== e.last) begin
          mismatches++;
          if (mismatches <= 10) $display("result mismatch: expected %p got %p", e, rsp);
        end
      end
    end
  end

  // Receiver back-pressure: short random stalls, occasional long ones, and the
  // long hold-off requested by the backpressure test, counted here cycle by cycle.
  int hold_left = 0;
  int stall_run = 0;
  always @(posedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      rsp_stall <= 1'b1;
      hold_left--;
    end else if (stall_run > 0) begin
      rsp_stall <= 1'b1;
      stall_run--;
    end else begin
      rsp_stall <= 1'b0;
      if (!calm && $urandom_range(0, 3) == 0)
        stall_run = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    end
  end

  // One request transfer; valid stays up when no gap follows.
  task automatic send_req(input req_t r);
    int gap;
    req <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    predict_relay(r);
    if (calm) gap = 0;
    else if ($urandom_range(0, 1) == 0) gap = 0;
    else if ($urandom_range(0, 9) < 8) gap = $urandom_range(1, 3);
    else gap = $urandom_range(8, 30);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic req_t mk_req(logic [2:0] f, logic [47:0] mac, logic [15:0] seq,
                                  logic [15:0] len, logic [31:0] now,
                                  logic [2:0] si, logic [5:0] bi, logic [7:0] bv);
    req_t r;
    r.func = f; r.sender_mac = mac; r.seq_num = seq; r.frame_len = len;
    r.now_ms = now; r.slot_index = si; r.byte_index = bi; r.byte_value = bv;
    return r;
  endfunction

  function automatic logic [47:0] rand_mac();
    return {$urandom(), $urandom()};
  endfunction

  // Unused fields carry noise so every input bit toggles.
  task automatic first_seen(logic [47:0] mac, logic [15:0] seq, logic [15:0] len,
                            logic [31:0] now);
    send_req(mk_req(FN_FIRST, mac, seq, len, now, $urandom, $urandom, $urandom));
  endtask

  task automatic write_byte(int s, int b, logic [7:0] v);
    send_req(mk_req(FN_WRITE, rand_mac(), $urandom, $urandom, $urandom, s, b, v));
  endtask

  task automatic dup_heard(logic [47:0] mac, logic [15:0] seq);
    send_req(mk_req(FN_DUP, mac, seq, $urandom, $urandom, $urandom, $urandom, $urandom));
  endtask

  task automatic tick_at(logic [31:0] now);
    send_req(mk_req(FN_TICK, rand_mac(), $urandom, $urandom, now,
                    $urandom, $urandom, $urandom));
  endtask

  // Reads only bytes written since the slot was claimed; writes one first if needed.
  task automatic read_byte_at(int s, int b);
    if (!sh_valid_byte[s*FRAME_MAX+b]) write_byte(s, b, $urandom);
    send_req(mk_req(FN_READ, rand_mac(), $urandom, $urandom, $urandom, s, b, $urandom));
  endtask

  // Any fire time is at or below the top of the 32-bit range.
  task automatic clear_table();
    tick_at(32'hFFFF_FFFF);
  endtask

  // Sender pauses until the DUT owes nothing, then lets no-result items settle.
  task automatic drain();
    req_valid <= 1'b0;
    while (relay_reports_q.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [15:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_JMIN:   sh_jmin = v;
      REG_JMAX:   sh_jmax = v;
      REG_THRESH: sh_thresh = v[7:0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic [15:0] jmin, logic [15:0] jmax, logic [7:0] thr);
    drain();
    write_cfg(REG_JMIN, jmin);
    write_cfg(REG_JMAX, jmax);
    write_cfg(REG_THRESH, {8'd0, thr});
  endtask

  // Reset settings: limits of frame length, full table, duplicates, unknown codes.
  task automatic test_directed();
    logic [47:0] mac_a;
    mac_a = 48'hFFFF_FFFF_FFFF;
    clock_ms = 32'd1000;
    first_seen(mac_a, 16'hFFFF, 16'd64, clock_ms);          // longest frame held
    first_seen(48'd0, 16'd0, 16'd0, clock_ms);              // empty frame
    first_seen(rand_mac(), $urandom, 16'd65, clock_ms);     // too long
    first_seen(rand_mac(), $urandom, 16'hFFFF, clock_ms);   // too long, all bits
    write_byte(0, 0, 8'h00);
    write_byte(0, 63, 8'hFF);
    read_byte_at(0, 0);
    read_byte_at(0, 63);
    dup_heard(mac_a, 16'hFFFF);
    dup_heard(mac_a, 16'hFFFE);                             // no matching slot
    for (int f = 5; f < 8; f++)
      send_req(mk_req(f[2:0], rand_mac(), $urandom, $urandom, $urandom,
                      $urandom, $urandom, $urandom));
    for (int i = 0; i < 6; i++) first_seen(rand_mac(), $urandom, $urandom_range(1, 64), clock_ms);
    first_seen(rand_mac(), $urandom, 16'd5, clock_ms);      // table full
    tick_at(clock_ms + 32'd9);                              // nothing due yet
    tick_at(clock_ms + 32'd100);                            // every slot due
  endtask

  // Window extremes, an inverted window, and both threshold extremes.
  task automatic test_jitter_window();
    logic [15:0] mins[6] = '{16'd0, 16'd0, 16'hFFFF, 16'd500, 16'd7, 16'd1};
    logic [15:0] maxs[6] = '{16'd0, 16'hFFFF, 16'hFFFF, 16'd20, 16'd7, 16'd300};
    logic [7:0]  thrs[6] = '{8'd0, 8'hFF, 8'd1, 8'd3, 8'd2, 8'hFF};
    logic [47:0] m;
    logic [15:0] q;
    for (int k = 0; k < 6; k++) begin
      set_config(mins[k], maxs[k], thrs[k]);
      clock_ms = $urandom;
      clear_table();
      for (int i = 0; i < 3; i++) begin
        m = rand_mac();
        q = $urandom;
        first_seen(m, q, $urandom_range(1, 64), clock_ms);
        if (i == 0) dup_heard(m, q);
      end
      if (mins[k] > 0) tick_at(clock_ms + mins[k] - 1);
      tick_at(clock_ms + mins[k]);
      tick_at(clock_ms + 32'd65535);
    end
  endtask

  // Fire times that wrap past the top of the millisecond counter.
  task automatic test_time_wrap();
    set_config(16'd20, 16'd20, 8'd3);
    clear_table();
    first_seen(rand_mac(), $urandom, 16'd8, 32'hFFFF_FFF0);
    tick_at(32'hFFFF_FFF5);
    first_seen(rand_mac(), $urandom, 16'd8, 32'd5);
    tick_at(32'd10);
    tick_at(32'd30);
  endtask

  // Duplicate count stops at its ceiling rather than wrapping.
  task automatic test_dup_saturation();
    logic [47:0] m;
    logic [15:0] q;
    set_config(16'd0, 16'd0, 8'hFF);
    clear_table();
    m = rand_mac();
    q = $urandom;
    first_seen(m, q, 16'd33, 32'd50);
    calm = 1'b1;
    repeat (256) dup_heard(m, q);
    calm = 1'b0;
    tick_at(32'd50);
  endtask

  // Mostly well-formed relay lifecycles with random content, plus noise.
  task automatic test_random_traffic();
    int pick, s;
    logic [15:0] jmin;
    for (int phase = 0; phase < 3; phase++) begin
      jmin = $urandom_range(0, 50);
      set_config(jmin, jmin + $urandom_range(0, 150), $urandom_range(0, 5));
      clock_ms = $urandom;
      if (phase == 1) calm = 1'b1;
      for (int n = 0; n < 16; n++) begin
        pick = $urandom_range(0, 99);
        s = $urandom_range(0, SLOTS-1);
        if (pick < 35) begin
          case ($urandom_range(0, 9))
            0:       first_seen(rand_mac(), $urandom, 16'd0, clock_ms);
            1:       first_seen(rand_mac(), $urandom, $urandom_range(65, 65535), clock_ms);
            default: first_seen(rand_mac(), $urandom, $urandom_range(1, 64), clock_ms);
          endcase
          write_byte($urandom_range(0, SLOTS-1), $urandom, $urandom);
        end else if (pick < 55) begin
          if (sh_used[s] && $urandom_range(0, 3) != 0) dup_heard(sh_mac[s], sh_seq[s]);
          else dup_heard(rand_mac(), $urandom);
        end else if (pick < 75) begin
          clock_ms += $urandom_range(0, 120);
          tick_at(clock_ms);
        end else if (pick < 92) begin
          read_byte_at(s, $urandom_range(0, FRAME_MAX-1));
        end else if (pick < 96) begin
          write_byte(s, $urandom, $urandom);
        end else begin
          send_req(mk_req($urandom_range(5, 7), rand_mac(), $urandom, $urandom, $urandom,
                          $urandom, $urandom, $urandom));
        end
      end
      calm = 1'b0;
      clear_table();
    end
  endtask

  // Receiver holds off long enough that the block backs up onto its input.
  task automatic test_backpressure();
    drain();
    hold_req = 400;
    calm = 1'b1;
    for (int i = 0; i < 30; i++) read_byte_at($urandom_range(0, SLOTS-1), $urandom_range(0, 63));
    calm = 1'b0;
    drain();
  endtask

  initial begin
    sh_jmin = 16'd10;
    sh_jmax = 16'd100;
    sh_thresh = 8'd3;
    for (int s = 0; s < SLOTS; s++) sh_used[s] = 1'b0;
    for (int a = 0; a < SLOTS*FRAME_MAX; a++) begin
      sh_valid_byte[a] = 1'b0;
      sh_frame[a] = '0;
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_jitter_window();
    test_time_wrap();
    test_dup_saturation();
    test_random_traffic();
    test_backpressure();

    drain();
    if (mismatches == 0 && relay_reports_q.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

[sim.f]
+incdir+src
src/mrs_pkg.sv
src/mrs_slot_ram.sv
src/mrs_frame_ram.sv
src/mrs_jitter.sv
src/mesh_relay_suppressor.sv
tb/testbench.sv
